FILE: src/rational_to_stern_brocot_node_core_macros.svh
// assertion macros for the stern-brocot node core
`ifndef RATIONAL_TO_STERN_BROCOT_NODE_CORE_MACROS_SVH
`define RATIONAL_TO_STERN_BROCOT_NODE_CORE_MACROS_SVH
// implication checked on every edge outside reset
`define SBN_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sbn check failed");
// next-cycle implication
`define SBN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sbn check failed");
`endif

FILE: src/sbn_pkg.sv
// ---------------------------------------------------------------------------
// sbn_pkg
// shared widths, commands and status for the stern-brocot node core
// ---------------------------------------------------------------------------
`default_nettype none
package sbn_pkg;
    localparam int W = 32;
    localparam int CW = $clog2(W + 1);
    localparam int IW = $clog2(W);

    typedef struct packed {
        logic load;     // capture operands, start gcd unless an operand is zero
        logic step;     // run one iteration of the active unit
    } sbn_cmd_t;

    typedef struct packed {
        logic zero_in;  // an operand was zero
        logic busy;     // datapath still iterating
    } sbn_stat_t;
endpackage
`default_nettype wire

FILE: src/sbn_datapath.sv
// ---------------------------------------------------------------------------
// sbn_datapath
// gcd by subtraction-free remainder, then continued-fraction walk using a
// shared restoring divider and a shift-add multiplier, one bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module sbn_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sbn_pkg::sbn_cmd_t    cmd,
    output sbn_pkg::sbn_stat_t        stat,
    input  wire logic [sbn_pkg::W-1:0] num_in,
    input  wire logic [sbn_pkg::W-1:0] den_in,
    output logic [4*sbn_pkg::W:0]     result
);
    import sbn_pkg::*;

    localparam logic [3:0] P_GCDDIV = 4'd0, P_GCDEND = 4'd1, P_RDA = 4'd2,
                           P_RDB = 4'd3, P_CMP = 4'd4, P_DIV = 4'd5,
                           P_K = 4'd6, P_MUL = 4'd7, P_DONE = 4'd8,
                           P_RDA_END = 4'd9, P_RDB_END = 4'd10;

    logic [3:0] ph_reg, ph_next;
    logic [W-1:0] a_reg, a_next, b_reg, b_next, y_reg, y_next;
    logic [W-1:0] ln_reg, ln_next, ld_reg, ld_next, un_reg, un_next, ud_reg, ud_next;
    logic [W-1:0] q_reg, q_next, r_reg, r_next, dd_reg, dd_next, dv_reg, dv_next;
    logic [W-1:0] k_reg, k_next;
    logic [W-1:0] p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic gt_reg, gt_next, inv_reg, inv_next;
    logic [IW-1:0] kbit;

    // one restoring step
    logic [W:0] rsh;
    logic [W-1:0] dd_sh;
    always_comb begin
        rsh = {r_reg, dd_reg[W-1]};
        dd_sh = {dd_reg[W-2:0], 1'b0};
    end
    logic [W:0] rsub;
    assign rsub = rsh - {1'b0, dv_reg};

    // multiplier bit, most significant first
    assign kbit = IW'(cnt_reg - 1'b1);

    always_comb begin
        ph_next = ph_reg; a_next = a_reg; b_next = b_reg; y_next = y_reg;
        ln_next = ln_reg; ld_next = ld_reg; un_next = un_reg; ud_next = ud_reg;
        q_next = q_reg; r_next = r_reg; dd_next = dd_reg; dv_next = dv_reg;
        k_next = k_reg; p0_next = p0_reg; p1_next = p1_reg; p2_next = p2_reg;
        cnt_next = cnt_reg; gt_next = gt_reg; inv_next = inv_reg;
        if (cmd.load) begin
            a_next = num_in; b_next = den_in; y_next = den_in;
            ln_next = '0; ld_next = W'(1); un_next = W'(1); ud_next = '0;
            inv_next = (num_in == '0) || (den_in == '0);
            r_next = '0; dd_next = num_in; dv_next = den_in; q_next = '0;
            cnt_next = CW'(W);
            ph_next = inv_next ? P_DONE : P_GCDDIV;
        end else if (cmd.step) begin
            case (ph_reg)
                P_GCDDIV, P_RDA, P_RDB, P_DIV: begin
                    // divide dd by dv, one quotient bit a cycle
                    if (!rsub[W]) begin
                        r_next = rsub[W-1:0]; q_next = {q_reg[W-2:0], 1'b1};
                    end else begin
                        r_next = rsh[W-1:0]; q_next = {q_reg[W-2:0], 1'b0};
                    end
                    dd_next = dd_sh;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        case (ph_reg)
                            P_GCDDIV: ph_next = P_GCDEND;
                            P_RDA:    ph_next = P_RDA_END;
                            P_RDB:    ph_next = P_RDB_END;
                            default:  ph_next = P_K;
                        endcase
                    end
                end
                P_GCDEND: begin
                    y_next = r_reg;
                    r_next = '0; cnt_next = CW'(W);
                    if (r_reg == '0) begin
                        dd_next = a_reg; dv_next = y_reg; ph_next = P_RDA;
                    end else begin
                        dd_next = y_reg; dv_next = r_reg; ph_next = P_GCDDIV;
                    end
                end
                P_RDA_END: begin
                    a_next = q_reg; r_next = '0; cnt_next = CW'(W);
                    dd_next = b_reg; ph_next = P_RDB;
                end
                P_RDB_END: begin
                    b_next = q_reg; ph_next = P_CMP;
                end
                P_CMP: begin
                    if (a_reg == b_reg) ph_next = P_DONE;
                    else begin
                        gt_next = a_reg > b_reg;
                        dd_next = gt_next ? a_reg : b_reg;
                        dv_next = gt_next ? b_reg : a_reg;
                        r_next = '0; cnt_next = CW'(W); ph_next = P_DIV;
                    end
                end
                P_K: begin
                    k_next = (r_reg == '0) ? q_reg - 1'b1 : q_reg;
                    p0_next = '0; p1_next = '0; p2_next = '0;
                    cnt_next = CW'(W); ph_next = P_MUL;
                end
                P_MUL: begin
                    // shift-add: p0 = num*k, p1 = den*k of the upper bound if a > b, else of the lower; p2 = small*k
                    p0_next = {p0_reg[W-2:0], 1'b0}; p1_next = {p1_reg[W-2:0], 1'b0};
                    p2_next = {p2_reg[W-2:0], 1'b0};
                    if (k_reg[kbit]) begin
                        p0_next = p0_next + (gt_reg ? un_reg : ln_reg);
                        p1_next = p1_next + (gt_reg ? ud_reg : ld_reg);
                        p2_next = p2_next + dv_reg;
                    end
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        if (gt_reg) begin
                            ln_next = ln_reg + p0_next; ld_next = ld_reg + p1_next;
                            a_next = a_reg - p2_next;
                        end else begin
                            un_next = un_reg + p0_next; ud_next = ud_reg + p1_next;
                            b_next = b_reg - p2_next;
                        end
                        ph_next = P_CMP;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= P_DONE;
        end else begin
            ph_reg <= ph_next;
        end
        a_reg <= a_next; b_reg <= b_next; y_reg <= y_next;
        ln_reg <= ln_next; ld_reg <= ld_next; un_reg <= un_next; ud_reg <= ud_next;
        q_reg <= q_next; r_reg <= r_next; dd_reg <= dd_next; dv_reg <= dv_next;
        k_reg <= k_next; p0_reg <= p0_next; p1_reg <= p1_next; p2_reg <= p2_next;
        cnt_reg <= cnt_next; gt_reg <= gt_next; inv_reg <= inv_next;
    end

    assign stat = {inv_reg, (ph_reg != P_DONE)};
    assign result = {inv_reg, ud_reg, un_reg, ld_reg, ln_reg};
endmodule
`default_nettype wire

FILE: src/sbn_ctrl.sv
// ---------------------------------------------------------------------------
// sbn_ctrl
// sequencer: accepts a word, runs the datapath, holds the result word
// ---------------------------------------------------------------------------
`default_nettype none
module sbn_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sbn_pkg::sbn_cmd_t       cmd,
    input  wire sbn_pkg::sbn_stat_t stat,
    output logic                    cap
);
    import sbn_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_OUT = 2'd2;
    logic [1:0] st_reg, st_next;

    always_comb begin
        st_next = st_reg;
        cmd.load = 1'b0; cmd.step = 1'b0; cap = 1'b0;
        s_ready = (st_reg == S_IDLE);
        m_valid = (st_reg == S_OUT);
        case (st_reg)
            S_IDLE: if (s_valid) begin cmd.load = 1'b1; st_next = S_RUN; end
            S_RUN: begin
                if (stat.busy) cmd.step = 1'b1;
                else begin cap = 1'b1; st_next = S_OUT; end
            end
            S_OUT: if (m_ready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= S_IDLE;
        else st_reg <= st_next;
    end
endmodule
`default_nettype wire

FILE: src/rational_to_stern_brocot_node_core.sv
// ---------------------------------------------------------------------------
// rational_to_stern_brocot_node_core
// fraction to stern-brocot node interval
// ---------------------------------------------------------------------------
// usage:
//  s_axis takes one word {denominator, numerator}; m_axis returns one word
//  {upper_den, upper_num, lower_den, lower_num} with tuser = invalid.
//  one item at a time: s_axis_tready is high only while the core is idle.
//  the work is done by the bit-serial divider and shift-add multiplier: the
//  gcd runs one division per remainder step, reduction divides both
//  operands by the gcd, and each continued-fraction run does one division
//  and one multiplication; a fraction equal to one ends after reduction.
//  a zero operand skips the datapath and returns tuser set and the root interval.
//  the result word is held on m_axis until m_axis_tready; no new word is
//  taken meanwhile. reset clears the sequencer; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none
module rational_to_stern_brocot_node_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [63:0]   s_axis_tdata,   // numerator, denominator
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [127:0]       m_axis_tdata,   // lower_num, lower_den, upper_num, upper_den
    output logic               m_axis_tuser    // invalid
);
    import sbn_pkg::*;

    sbn_cmd_t  cmd;
    sbn_stat_t stat;
    logic cap;
    logic [4*W:0] res;
    logic [4*W:0] out_reg;

    sbn_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .cmd(cmd), .stat(stat), .cap(cap)
    );

    sbn_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .num_in(s_axis_tdata[W-1:0]), .den_in(s_axis_tdata[2*W-1:W]), .result(res)
    );

    always_ff @(posedge aclk) begin
        if (cap) out_reg <= res;
    end

    assign m_axis_tdata = out_reg[4*W-1:0];
    assign m_axis_tuser = out_reg[4*W];
endmodule
`default_nettype wire

FILE: src/sbn_checker.sv
// ---------------------------------------------------------------------------
// sbn_checker
// port-level checks on the node core
// ---------------------------------------------------------------------------
`default_nettype none
`include "rational_to_stern_brocot_node_core_macros.svh"
module sbn_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata,
    input wire logic         m_axis_tuser
);
    // one item in flight: never ready while a result waits
    `SBN_ASSERT_IMPL(a_excl, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    // invalid word carries the root interval
    `SBN_ASSERT_IMPL(a_root, aclk, aresetn, (m_axis_tvalid && m_axis_tuser),
        (m_axis_tdata == {32'd0, 32'd1, 32'd1, 32'd0}))
    // accepted word stops the input side next cycle
    `SBN_ASSERT_NEXT(a_busy, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // stalled result holds
    `SBN_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        (m_axis_tvalid && $stable(m_axis_tdata)))
endmodule
bind rational_to_stern_brocot_node_core sbn_checker u_sbn_checker (.*);
`default_nettype wire
